// File: sv/obb_pkg.sv
// Package with the shared widths and types of the oriented rectangle overlap test.
package obb_pkg;
    localparam int CW = 24;
    localparam int HW = 20;
    localparam int TW = 16;
    localparam int PW = 40;
    localparam int QW = 58;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [HW-1:0]        hx;
        logic [HW-1:0]        hy;
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
    } t_rect;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } t_point;

    typedef t_point t_corners [4];
endpackage

// File: sv/obb_corners.sv
// Corner generation stage: world corners of one rectangle, registered.
module obb_corners (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  obb_pkg::t_rect       i_rect,
    output obb_pkg::t_point      o_pt [4]
);
    logic signed [obb_pkg::HW:0]   w_lx [4];
    logic signed [obb_pkg::HW:0]   w_ly [4];
    logic signed [obb_pkg::PW-1:0] w_cx;
    logic signed [obb_pkg::PW-1:0] w_cy;
    logic signed [obb_pkg::PW-1:0] w_c;
    logic signed [obb_pkg::PW-1:0] w_s;

    assign w_cx = obb_pkg::PW'(i_rect.cx) <<< 14;
    assign w_cy = obb_pkg::PW'(i_rect.cy) <<< 14;
    assign w_c  = obb_pkg::PW'(i_rect.c);
    assign w_s  = obb_pkg::PW'(i_rect.s);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_lx[k] = k[0] ? $signed({1'b0, i_rect.hx}) : -$signed({1'b0, i_rect.hx});
            w_ly[k] = k[1] ? $signed({1'b0, i_rect.hy}) : -$signed({1'b0, i_rect.hy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                o_pt[k].x <= w_cx + w_c * obb_pkg::PW'(w_lx[k])
                                  - w_s * obb_pkg::PW'(w_ly[k]);
                o_pt[k].y <= w_cy + w_s * obb_pkg::PW'(w_lx[k])
                                  + w_c * obb_pkg::PW'(w_ly[k]);
            end
        end
    end
endmodule

// File: sv/obb_axis.sv
// Projection of both rectangles on one axis with the interval test, two stages.
module obb_axis (
    input  logic                        i_clk,
    input  logic                        i_en1,
    input  logic                        i_en2,
    input  logic signed [obb_pkg::TW:0] i_ax,
    input  logic signed [obb_pkg::TW:0] i_ay,
    input  logic                        i_skip,
    input  obb_pkg::t_point             i_a [4],
    input  obb_pkg::t_point             i_b [4],
    output logic                        o_meet
);
    logic signed [obb_pkg::QW-1:0] r_pa [4];
    logic signed [obb_pkg::QW-1:0] r_pb [4];
    logic                          r_skip;
    logic signed [obb_pkg::QW-1:0] w_amin, w_amax, w_bmin, w_bmax;
    logic signed [obb_pkg::QW-1:0] w_ax;
    logic signed [obb_pkg::QW-1:0] w_ay;

    assign w_ax = obb_pkg::QW'(i_ax);
    assign w_ay = obb_pkg::QW'(i_ay);

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_skip <= i_skip;
            for (int k = 0; k < 4; k++) begin
                r_pa[k] <= w_ax * obb_pkg::QW'(i_a[k].x) + w_ay * obb_pkg::QW'(i_a[k].y);
                r_pb[k] <= w_ax * obb_pkg::QW'(i_b[k].x) + w_ay * obb_pkg::QW'(i_b[k].y);
            end
        end
    end

    always_comb begin
        w_amin = r_pa[0]; w_amax = r_pa[0];
        w_bmin = r_pb[0]; w_bmax = r_pb[0];
        for (int k = 1; k < 4; k++) begin
            if (r_pa[k] < w_amin) w_amin = r_pa[k];
            if (r_pa[k] > w_amax) w_amax = r_pa[k];
            if (r_pb[k] < w_bmin) w_bmin = r_pb[k];
            if (r_pb[k] > w_bmax) w_bmax = r_pb[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            o_meet <= r_skip || (w_amin <= w_bmax && w_bmin <= w_amax);
        end
    end
endmodule

// File: sv/obb_separating_axis_overlap.sv
// Top level of the oriented rectangle separating axis overlap test.
// One item is accepted in every cycle; a stall holds the whole pipeline.
// The stages are corner generation, projection, interval test and output.
// Reset, synchronous and active low, clears the valid bits of all stages.
module obb_separating_axis_overlap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [23:0]          i_first_center_x,
    input  logic signed [23:0]          i_first_center_y,
    input  logic [19:0]                 i_first_half_x,
    input  logic [19:0]                 i_first_half_y,
    input  logic signed [15:0]          i_first_cosine,
    input  logic signed [15:0]          i_first_sine,
    input  logic signed [23:0]          i_second_center_x,
    input  logic signed [23:0]          i_second_center_y,
    input  logic [19:0]                 i_second_half_x,
    input  logic [19:0]                 i_second_half_y,
    input  logic signed [15:0]          i_second_cosine,
    input  logic signed [15:0]          i_second_sine,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_overlap
);
    obb_pkg::t_rect  w_a, w_b, r_a, r_b;
    obb_pkg::t_point w_pa [4];
    obb_pkg::t_point w_pb [4];
    logic [3:0]      r_v;
    logic            w_en;
    logic [3:0]      w_meet;
    logic signed [obb_pkg::TW:0] w_ax [4];
    logic signed [obb_pkg::TW:0] w_ay [4];
    logic [3:0]      w_skip;

    assign w_en    = !i_stall || !r_v[3];
    assign o_stall = !w_en;
    assign o_valid = r_v[3];

    assign w_a = '{i_first_center_x, i_first_center_y, i_first_half_x,
                   i_first_half_y, i_first_cosine, i_first_sine};
    assign w_b = '{i_second_center_x, i_second_center_y, i_second_half_x,
                   i_second_half_y, i_second_cosine, i_second_sine};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= w_a;
            r_b <= w_b;
        end
    end

    obb_corners u_ca (.i_clk(i_clk), .i_en(w_en), .i_rect(w_a), .o_pt(w_pa));
    obb_corners u_cb (.i_clk(i_clk), .i_en(w_en), .i_rect(w_b), .o_pt(w_pb));

    assign w_ax[0] = 17'(r_a.c);  assign w_ay[0] = 17'(r_a.s);
    assign w_ax[1] = -17'(r_a.s); assign w_ay[1] = 17'(r_a.c);
    assign w_ax[2] = 17'(r_b.c);  assign w_ay[2] = 17'(r_b.s);
    assign w_ax[3] = -17'(r_b.s); assign w_ay[3] = 17'(r_b.c);
    assign w_skip  = {r_b.hx == '0, r_b.hy == '0, r_a.hx == '0, r_a.hy == '0};

    for (genvar g = 0; g < 4; g++) begin : g_axis
        obb_axis u_ax (
            .i_clk(i_clk), .i_en1(w_en), .i_en2(w_en),
            .i_ax(w_ax[g]), .i_ay(w_ay[g]), .i_skip(w_skip[g]),
            .i_a(w_pa), .i_b(w_pb), .o_meet(w_meet[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_overlap <= &w_meet;
        end
    end

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without a pending result");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0]) else $error("accepted item lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_overlap)))
        else $error("stalled result changed");
`endif
endmodule

// File: verif/tb_obb_separating_axis_overlap.sv
// Testbench for the oriented rectangle overlap test, with a bit-exact predictor.
module tb_obb_separating_axis_overlap;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        obb_pkg::t_rect first;
        obb_pkg::t_rect second;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [23:0] i_first_center_x = '0;
    logic signed [23:0] i_first_center_y = '0;
    logic [19:0] i_first_half_x = '0;
    logic [19:0] i_first_half_y = '0;
    logic signed [15:0] i_first_cosine = '0;
    logic signed [15:0] i_first_sine = '0;
    logic signed [23:0] i_second_center_x = '0;
    logic signed [23:0] i_second_center_y = '0;
    logic [19:0] i_second_half_x = '0;
    logic [19:0] i_second_half_y = '0;
    logic signed [15:0] i_second_cosine = '0;
    logic signed [15:0] i_second_sine = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_overlap;

    obb_separating_axis_overlap dut (.*);

    t_pair pending_pairs[$];
    bit expected_overlaps[$];
    int mismatches = 0;
    int cycles = 0;
    bit stimulus_done = 0;
    bit calm = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic void project_rect(input obb_pkg::t_rect r, input longint ax,
                                         input longint ay,
                                         output longint lo, output longint hi);
        longint lx, ly, px, py, p;
        for (int k = 0; k < 4; k++) begin
            lx = (k & 1) ? longint'(r.hx) : -longint'(r.hx);
            ly = (k & 2) ? longint'(r.hy) : -longint'(r.hy);
            px = longint'(r.cx) * 16384 + longint'(r.c) * lx - longint'(r.s) * ly;
            py = longint'(r.cy) * 16384 + longint'(r.s) * lx + longint'(r.c) * ly;
            p = ax * px + ay * py;
            if (k == 0 || p < lo) lo = p;
            if (k == 0 || p > hi) hi = p;
        end
    endfunction

    function automatic bit intervals_meet(input t_pair q, input longint ax, input longint ay,
                                          input longint scale);
        longint alo, ahi, blo, bhi;
        if (scale == 0) return 1'b1;
        project_rect(q.first, ax, ay, alo, ahi);
        project_rect(q.second, ax, ay, blo, bhi);
        return alo <= bhi && blo <= ahi;
    endfunction

    function automatic bit rects_overlap(input t_pair q);
        longint ac, as_, bc, bs;
        ac = q.first.c;
        as_ = q.first.s;
        bc = q.second.c;
        bs = q.second.s;
        return intervals_meet(q, ac, as_, q.first.hy) && intervals_meet(q, -as_, ac, q.first.hx)
            && intervals_meet(q, bc, bs, q.second.hy)
            && intervals_meet(q, -bs, bc, q.second.hx);
    endfunction

    function automatic obb_pkg::t_rect random_rect(input int span, input int half_max);
        obb_pkg::t_rect r;
        int ang;
        r.cx = $urandom_range(0, 2 * span) - span;
        r.cy = $urandom_range(0, 2 * span) - span;
        r.hx = $urandom_range(0, half_max);
        r.hy = $urandom_range(0, half_max);
        ang = $urandom_range(0, 7);
        case (ang)
            0: begin r.c = 16384; r.s = 0; end
            1: begin r.c = 0; r.s = 16384; end
            2: begin r.c = 11585; r.s = 11585; end
            3: begin r.c = -11585; r.s = 11585; end
            4: begin r.c = 14189; r.s = -8192; end
            5: begin r.c = -16384; r.s = 0; end
            6: begin r.c = $urandom_range(0, 32768) - 16384;
                     r.s = $urandom_range(0, 32768) - 16384; end
            default: begin r.c = $urandom; r.s = $urandom; end
        endcase
        return r;
    endfunction

    function automatic obb_pkg::t_rect fixed_rect(input int cx, input int cy, input int hx,
                                                  input int hy, input int c, input int s);
        obb_pkg::t_rect r;
        r.cx = cx; r.cy = cy; r.hx = hx; r.hy = hy; r.c = c; r.s = s;
        return r;
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        t_pair q;
        int span;
        // Extremes, touching edges, zero sizes and rotations.
        q.first = fixed_rect(0, 0, 256, 256, 16384, 0);
        q.second = fixed_rect(512, 0, 256, 256, 16384, 0);
        pending_pairs.push_back(q);
        q.second = fixed_rect(513, 0, 256, 256, 16384, 0);
        pending_pairs.push_back(q);
        q.second = fixed_rect(600, 0, 256, 256, 11585, 11585);
        pending_pairs.push_back(q);
        q.first = fixed_rect(0, 0, 0, 0, 16384, 0);
        q.second = fixed_rect(0, 0, 0, 0, 0, 16384);
        pending_pairs.push_back(q);
        q.first = fixed_rect(-8388608, -8388608, 1048575, 1048575, -16384, -16384);
        q.second = fixed_rect(8388607, 8388607, 1048575, 1048575, 16384, 16384);
        pending_pairs.push_back(q);
        q.first = fixed_rect(8388607, -8388608, 1048575, 0, -32768, 32767);
        q.second = fixed_rect(-8388608, 8388607, 0, 1048575, 32767, -32768);
        pending_pairs.push_back(q);
        q.first = fixed_rect(100, 100, 1000, 0, 0, 0);
        q.second = fixed_rect(-100, 50, 0, 1000, 0, 0);
        pending_pairs.push_back(q);
        q.first = fixed_rect(0, 0, 1000, 10, 11585, 11585);
        q.second = fixed_rect(700, -700, 1000, 10, -11585, 11585);
        pending_pairs.push_back(q);
        q.first = fixed_rect(0, 0, 1048575, 1048575, 0, -16384);
        q.second = fixed_rect(-1, -1, 1, 1, 14189, -8192);
        pending_pairs.push_back(q);
        for (int n = 0; n < 2000; n++) begin
            case ($urandom_range(0, 3))
                0: span = 2000;
                1: span = 200000;
                2: span = 8388607;
                default: span = 20000;
            endcase
            q.first = random_rect(span, (n % 3 == 0) ? 1048575 : span / 2 + 1);
            q.second = random_rect(span, (n % 3 == 0) ? 1048575 : span / 2 + 1);
            if (span == 8388607) begin
                q.first.cx = $urandom; q.first.cy = $urandom;
                q.second.cx = $urandom; q.second.cy = $urandom;
                q.first.hx = $urandom; q.second.hy = $urandom;
            end
            pending_pairs.push_back(q);
        end
        stimulus_done = 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 8) i_rst_n <= 1'b1;
        if (pending_pairs.size() < 200) calm <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_pair q;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_overlaps.push_back(rects_overlap(pending_pairs.pop_front()));
            end
            if (i_valid && o_stall) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 10);
                i_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                q = pending_pairs[0];
                i_valid <= 1'b1;
                i_first_center_x <= q.first.cx;
                i_first_center_y <= q.first.cy;
                i_first_half_x <= q.first.hx;
                i_first_half_y <= q.first.hy;
                i_first_cosine <= q.first.c;
                i_first_sine <= q.first.s;
                i_second_center_x <= q.second.cx;
                i_second_center_y <= q.second.cy;
                i_second_half_x <= q.second.hx;
                i_second_half_y <= q.second.hy;
                i_second_cosine <= q.second.c;
                i_second_sine <= q.second.s;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_overlaps.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected result, overlap %0b", o_overlap);
                end else begin
                    want = expected_overlaps.pop_front();
                    if (o_overlap !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Overlap mismatch: expected %0b, got %0b", want, o_overlap);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        @(posedge i_clk);
        while ((pending_pairs.size() > 0 || expected_overlaps.size() > 0 || i_valid)
               && cycles < 200000)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (cycles >= 200000) begin
            $display("DONE: errors detected");
        end else if (mismatches == 0 && expected_overlaps.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
